### sv/slle_pkg.sv
`timescale 1ns / 1ps

package slle_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int NUM_LISTS = 4;
  localparam int KEY_BITS  = 32;

  localparam int NODES   = NUM_SLOTS + NUM_LISTS;
  localparam int CMD_W   = 3;
  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int LIST_W  = $clog2(NUM_LISTS);
  localparam int NODE_W  = $clog2(NODES);
  localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int OWN_W   = $clog2(NUM_LISTS + 1);

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESET    = 3'd0,
    CMD_DETACH   = 3'd1,
    CMD_INS_CUR  = 3'd2,
    CMD_INS_SORT = 3'd3,
    CMD_REMOVE   = 3'd4,
    CMD_ADVANCE  = 3'd5
  } cmd_e;

  function automatic logic is_marker(node_t n);
    return n >= node_t'(NUM_SLOTS);
  endfunction

  function automatic logic [LIST_W-1:0] marker_idx(node_t n);
    node_t t;
    t = n - node_t'(NUM_SLOTS);
    return t[LIST_W-1:0];
  endfunction

endpackage

### sv/sorted_linked_list_engine_unit.sv
// Flow: each item is decoded, then unlinked, linked or advanced, and finished;
//   a sorted insert first walks the list, at most NUM_SLOTS links.
// Items are handled one at a time; the next item is accepted once the engine is
//   idle again after the result is loaded, and a held result stalls the input.
// Reset: asynchronous, active low; all lists empty, cursors on their end
//   markers, every slot on no list. No clearing pass is needed.
`timescale 1ns / 1ps

module sorted_linked_list_engine_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [slle_pkg::CMD_W-1:0]    command_i,
  input  logic [slle_pkg::LIST_W-1:0]   list_id_i,
  input  logic [slle_pkg::SLOT_W-1:0]   slot_i,
  input  logic [slle_pkg::KEY_BITS-1:0] item_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [slle_pkg::CNT_W-1:0]    count_after_o,
  output logic                          error_o,
  output logic [slle_pkg::SLOT_W-1:0]   cursor_slot_o,
  output logic                          cursor_valid_o
);
  import slle_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DECODE = 10'b00_0000_0010,
    S_UNLINK = 10'b00_0000_0100,
    S_PREV   = 10'b00_0000_1000,
    S_WALK   = 10'b00_0001_0000,
    S_LINK1  = 10'b00_0010_0000,
    S_LINK2  = 10'b00_0100_0000,
    S_ADV1   = 10'b00_1000_0000,
    S_ADV2   = 10'b01_0000_0000,
    S_FINISH = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // link memories, one read and one write port each
  node_t next_mem [NODES];
  node_t prev_mem [NODES];
  node_t next_rd_q, prev_rd_q, next_ra_q, prev_ra_q;
  node_t next_ra, prev_ra, next_wa, next_wd, prev_wa, prev_wd;
  logic  next_we, prev_we;
  node_t next_val, prev_val;

  // marker entries read as self links until written
  logic [NUM_LISTS-1:0] nvalid_q, pvalid_q;

  logic [KEY_BITS-1:0] key_q    [NUM_SLOTS];
  logic [OWN_W-1:0]    owner_q  [NUM_SLOTS];
  node_t               cursor_q [NUM_LISTS];
  logic [CNT_W-1:0]    count_q  [NUM_LISTS];

  cmd_e                cmd_q;
  logic [LIST_W-1:0]   lst_q;
  logic [SLOT_W-1:0]   s_q;
  logic [KEY_BITS-1:0] v_q;
  node_t               p_q, n_q;
  logic                walk_sort_q;
  logic                err_q, cvalid_q;
  logic [SLOT_W-1:0]   cslot_q;

  logic                out_valid_q, out_err_q, out_cvalid_q;
  logic [CNT_W-1:0]    out_count_q;
  logic [SLOT_W-1:0]   out_cslot_q;

  node_t               m_node, s_node;
  logic [OWN_W-1:0]    own_s, own_m1;
  logic [KEY_BITS-1:0] walk_key;
  logic                walk_stop, v_max, out_free;

  assign m_node   = node_t'(NUM_SLOTS) + node_t'(lst_q);
  assign s_node   = node_t'(s_q);
  assign own_s    = owner_q[s_q];
  assign own_m1   = own_s - OWN_W'(1);
  assign v_max    = (v_q == '1);
  assign out_free = !out_valid_q || out_ready_i;

  assign next_val = (is_marker(next_ra_q) && !nvalid_q[marker_idx(next_ra_q)]) ?
                    next_ra_q : next_rd_q;
  assign prev_val = (is_marker(prev_ra_q) && !pvalid_q[marker_idx(prev_ra_q)]) ?
                    prev_ra_q : prev_rd_q;

  assign walk_key  = (next_val < node_t'(NUM_SLOTS)) ?
                     key_q[next_val[SLOT_W-1:0]] : '1;
  assign walk_stop = !walk_sort_q || (next_val == m_node) || (walk_key > v_q);

  always_comb begin
    state_d = state_q;
    next_ra = '0;
    prev_ra = '0;
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    prev_we = 1'b0;
    prev_wa = '0;
    prev_wd = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (cmd_q)
          CMD_DETACH, CMD_REMOVE: begin
            if (own_s != '0) begin
              next_ra = s_node;
              prev_ra = s_node;
              state_d = S_UNLINK;
            end else begin
              state_d = S_FINISH;
            end
          end
          CMD_INS_CUR: begin
            if (own_s != '0) begin
              state_d = S_FINISH;
            end else begin
              prev_ra = cursor_q[lst_q];
              state_d = S_PREV;
            end
          end
          CMD_INS_SORT: begin
            if (own_s != '0) begin
              state_d = S_FINISH;
            end else if (v_max) begin
              prev_ra = m_node;
              state_d = S_PREV;
            end else begin
              next_ra = m_node;
              state_d = S_WALK;
            end
          end
          CMD_ADVANCE: begin
            next_ra = cursor_q[lst_q];
            state_d = S_ADV1;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_UNLINK: begin
        prev_we = 1'b1;
        prev_wa = next_val;
        prev_wd = prev_val;
        next_we = 1'b1;
        next_wa = prev_val;
        next_wd = next_val;
        state_d = S_FINISH;
      end
      S_PREV: begin
        next_ra = prev_val;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (walk_stop) begin
          state_d = S_LINK1;
        end else begin
          next_ra = next_val;
        end
      end
      S_LINK1: begin
        next_we = 1'b1;
        next_wa = s_node;
        next_wd = n_q;
        prev_we = 1'b1;
        prev_wa = s_node;
        prev_wd = p_q;
        state_d = S_LINK2;
      end
      S_LINK2: begin
        next_we = 1'b1;
        next_wa = p_q;
        next_wd = s_node;
        prev_we = 1'b1;
        prev_wa = n_q;
        prev_wd = s_node;
        state_d = S_FINISH;
      end
      S_ADV1: begin
        if (next_val == m_node) begin
          next_ra = m_node;
          state_d = S_ADV2;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_ADV2: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    next_rd_q <= next_mem[next_ra];
    prev_rd_q <= prev_mem[prev_ra];
    next_ra_q <= next_ra;
    prev_ra_q <= prev_ra;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nvalid_q    <= '0;
      pvalid_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) owner_q[i] <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        cursor_q[i] <= node_t'(NUM_SLOTS + i);
        count_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (next_we && is_marker(next_wa)) nvalid_q[marker_idx(next_wa)] <= 1'b1;
      if (prev_we && is_marker(prev_wa)) pvalid_q[marker_idx(prev_wa)] <= 1'b1;
      if (state_q == S_FINISH && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_DECODE: begin
          if (cmd_q == CMD_RESET) begin
            nvalid_q[lst_q] <= 1'b0;
            pvalid_q[lst_q] <= 1'b0;
            cursor_q[lst_q] <= m_node;
            count_q[lst_q]  <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (owner_q[i] == OWN_W'(lst_q) + OWN_W'(1)) owner_q[i] <= '0;
            end
          end
        end
        S_UNLINK: begin
          if (cursor_q[lst_q] == s_node) cursor_q[lst_q] <= prev_val;
          owner_q[s_q] <= '0;
          if (count_q[lst_q] != '0) count_q[lst_q] <= count_q[lst_q] - CNT_W'(1);
        end
        S_LINK2: begin
          owner_q[s_q]   <= OWN_W'(lst_q) + OWN_W'(1);
          count_q[lst_q] <= count_q[lst_q] + CNT_W'(1);
        end
        S_ADV1: begin
          if (next_val != m_node) cursor_q[lst_q] <= next_val;
        end
        S_ADV2: begin
          cursor_q[lst_q] <= next_val;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_q    <= cmd_e'(command_i);
          lst_q    <= list_id_i;
          s_q      <= slot_i;
          v_q      <= item_value_i;
          err_q    <= 1'b0;
          cslot_q  <= '0;
          cvalid_q <= 1'b0;
        end
      end
      S_DECODE: begin
        case (cmd_q)
          CMD_DETACH, CMD_REMOVE: begin
            if (own_s != '0) begin
              lst_q <= own_m1[LIST_W-1:0];
            end else if (cmd_q == CMD_REMOVE) begin
              err_q <= 1'b1;
            end
          end
          CMD_INS_CUR, CMD_INS_SORT: begin
            if (own_s != '0) begin
              err_q <= 1'b1;
            end else begin
              key_q[s_q]  <= v_q;
              walk_sort_q <= (cmd_q == CMD_INS_SORT) && !v_max;
              p_q         <= m_node;
            end
          end
          default: ;
        endcase
      end
      S_PREV: begin
        p_q <= prev_val;
      end
      S_WALK: begin
        if (walk_stop) begin
          n_q <= next_val;
        end else begin
          p_q <= next_val;
        end
      end
      S_ADV1: begin
        if (next_val != m_node && next_val < node_t'(NUM_SLOTS)) begin
          cslot_q  <= next_val[SLOT_W-1:0];
          cvalid_q <= 1'b1;
        end
      end
      S_ADV2: begin
        if (next_val < node_t'(NUM_SLOTS)) begin
          cslot_q  <= next_val[SLOT_W-1:0];
          cvalid_q <= 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_count_q  <= count_q[lst_q];
          out_err_q    <= err_q;
          out_cslot_q  <= cslot_q;
          out_cvalid_q <= cvalid_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign count_after_o  = out_count_q;
  assign error_o        = out_err_q;
  assign cursor_slot_o  = out_cslot_q;
  assign cursor_valid_o = out_cvalid_q;

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DECODE)
    else $error("accepted item did not start decode");

  a_link_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LINK2 |-> owner_q[s_q] == '0 && count_q[lst_q] < CNT_W'(NUM_SLOTS))
    else $error("linking a slot that is owned or into a full list");

  a_unlink_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UNLINK |-> owner_q[s_q] != '0)
    else $error("unlinking a slot on no list");

  a_err_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cursor_valid_o |-> !error_o)
    else $error("error and valid cursor in one result");

  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
    else $error("finished item not presented");

endmodule

### bench/slle_result_checker.sv
`timescale 1ns / 1ps

module slle_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [slle_pkg::CMD_W-1:0]    command_i,
  input  logic [slle_pkg::LIST_W-1:0]   list_id_i,
  input  logic [slle_pkg::SLOT_W-1:0]   slot_i,
  input  logic [slle_pkg::KEY_BITS-1:0] item_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [slle_pkg::CNT_W-1:0]    count_after_i,
  input  logic                          error_i,
  input  logic [slle_pkg::SLOT_W-1:0]   cursor_slot_i,
  input  logic                          cursor_valid_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            results_seen_o,
  output int                            error_results_o,
  output int                            cursor_hits_o
);
  import slle_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic              err;
    logic [SLOT_W-1:0] cslot;
    logic              cvalid;
  } list_result_t;

  node_t               next_q   [NODES];
  node_t               prev_q   [NODES];
  logic [KEY_BITS-1:0] key_q    [NUM_SLOTS];
  logic [OWN_W-1:0]    owner_q  [NUM_SLOTS];
  node_t               cursor_q [NUM_LISTS];
  logic [CNT_W-1:0]    count_q  [NUM_LISTS];

  list_result_t expected_results [$];

  function automatic node_t fix_node(input node_t n);
    return (n < node_t'(NODES)) ? n : '0;
  endfunction

  function automatic logic [KEY_BITS-1:0] key_of(input node_t n);
    return (n < node_t'(NUM_SLOTS)) ? key_q[n[SLOT_W-1:0]] : {KEY_BITS{1'b1}};
  endfunction

  function automatic node_t marker_of(input logic [LIST_W-1:0] l);
    return node_t'(NUM_SLOTS) + node_t'(l);
  endfunction

  task automatic empty_list(input logic [LIST_W-1:0] l);
    node_t m;
    m = marker_of(l);
    next_q[m]   = m;
    prev_q[m]   = m;
    cursor_q[l] = m;
    count_q[l]  = '0;
    for (int s = 0; s < NUM_SLOTS; s++)
      if (owner_q[s] == OWN_W'(l) + 1'b1) owner_q[s] = '0;
  endtask

  task automatic link_after(input logic [LIST_W-1:0] l, input node_t p,
                            input logic [SLOT_W-1:0] s);
    node_t n;
    n = fix_node(next_q[p]);
    next_q[node_t'(s)] = n;
    prev_q[n]          = node_t'(s);
    prev_q[node_t'(s)] = p;
    next_q[p]          = node_t'(s);
    owner_q[s] = OWN_W'(l) + 1'b1;
    count_q[l] = count_q[l] + 1'b1;
  endtask

  task automatic unlink(input logic [SLOT_W-1:0] s, output logic [LIST_W-1:0] l);
    node_t p, n;
    l = LIST_W'(owner_q[s] - 1'b1);
    p = fix_node(prev_q[node_t'(s)]);
    n = fix_node(next_q[node_t'(s)]);
    prev_q[n] = p;
    next_q[p] = n;
    if (cursor_q[l] == node_t'(s)) cursor_q[l] = p;
    owner_q[s] = '0;
    if (count_q[l] != 0) count_q[l] = count_q[l] - 1'b1;
  endtask

  task automatic clear_all();
    for (int i = 0; i < NODES; i++) begin
      next_q[i] = '0;
      prev_q[i] = '0;
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      key_q[s]   = '0;
      owner_q[s] = '0;
    end
    for (int l = 0; l < NUM_LISTS; l++) empty_list(LIST_W'(l));
  endtask

  task automatic apply_command(input logic [CMD_W-1:0] c, input logic [LIST_W-1:0] l,
                               input logic [SLOT_W-1:0] s, input logic [KEY_BITS-1:0] v,
                               output list_result_t r);
    node_t m, p, n;
    logic [LIST_W-1:0] cl;
    r  = '0;
    cl = l;
    m  = marker_of(l);
    case (c)
      CMD_RESET: empty_list(l);
      CMD_DETACH: if (owner_q[s] != 0) unlink(s, cl);
      CMD_INS_CUR, CMD_INS_SORT: begin
        if (owner_q[s] != 0) begin
          r.err = 1'b1;
        end else begin
          key_q[s] = v;
          if (c == CMD_INS_CUR) begin
            p = fix_node(prev_q[fix_node(cursor_q[l])]);
          end else if (&v) begin
            p = fix_node(prev_q[m]);
          end else begin
            p = m;
            for (int k = 0; k <= NUM_SLOTS; k++) begin
              n = fix_node(next_q[p]);
              if (n == m || key_of(n) > v) break;
              p = n;
            end
          end
          link_after(l, p, s);
        end
      end
      CMD_REMOVE: begin
        if (owner_q[s] == 0) r.err = 1'b1;
        else unlink(s, cl);
      end
      CMD_ADVANCE: begin
        n = fix_node(next_q[fix_node(cursor_q[l])]);
        if (n == m) n = fix_node(next_q[m]);
        cursor_q[l] = n;
        if (n < node_t'(NUM_SLOTS)) begin
          r.cslot  = n[SLOT_W-1:0];
          r.cvalid = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = count_q[cl];
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    list_result_t want;
    if (!rst_ni) begin
      clear_all();
      expected_results.delete();
      fail_count_o    = 0;
      results_seen_o  = 0;
      error_results_o = 0;
      cursor_hits_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, count_after %0d error %0d", $time,
                   count_after_i, error_i);
        end else begin
          want = expected_results.pop_front();
          results_seen_o++;
          if (want.err) error_results_o++;
          if (want.cvalid) cursor_hits_o++;
          check_field("count_after", 32'(want.count), 32'(count_after_i));
          check_field("error", 32'(want.err), 32'(error_i));
          check_field("cursor_slot", 32'(want.cslot), 32'(cursor_slot_i));
          check_field("cursor_valid", 32'(want.cvalid), 32'(cursor_valid_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_command(command_i, list_id_i, slot_i, item_value_i, want);
        expected_results.push_back(want);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

### bench/tb_sorted_linked_list_engine_unit.sv
`timescale 1ns / 1ps

module tb_sorted_linked_list_engine_unit;
  import slle_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int LONG_HOLD    = 250;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    command = '0;
  logic [LIST_W-1:0]   list_id = '0;
  logic [SLOT_W-1:0]   slot = '0;
  logic [KEY_BITS-1:0] item_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CNT_W-1:0]    count_after;
  logic                error;
  logic [SLOT_W-1:0]   cursor_slot;
  logic                cursor_valid;

  int fail_count, pending, results_seen, error_results, cursor_hits;
  int long_holds_asked = 0;
  int long_holds_done = 0;
  bit quiet = 1'b0;

  // rough occupancy, only to steer slot choice
  bit                linked [NUM_SLOTS];
  logic [LIST_W-1:0] holder [NUM_SLOTS];

  always #5 clk_i = ~clk_i;

  sorted_linked_list_engine_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .list_id_i      (list_id),
    .slot_i         (slot),
    .item_value_i   (item_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .count_after_o  (count_after),
    .error_o        (error),
    .cursor_slot_o  (cursor_slot),
    .cursor_valid_o (cursor_valid)
  );

  slle_result_checker result_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .command_i       (command),
    .list_id_i       (list_id),
    .slot_i          (slot),
    .item_value_i    (item_value),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .count_after_i   (count_after),
    .error_i         (error),
    .cursor_slot_i   (cursor_slot),
    .cursor_valid_i  (cursor_valid),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_seen_o  (results_seen),
    .error_results_o (error_results),
    .cursor_hits_o   (cursor_hits)
  );

  function automatic logic [SLOT_W-1:0] pick_slot(input bit want_linked);
    int start;
    start = $urandom_range(0, NUM_SLOTS - 1);
    if ($urandom_range(0, 6) != 0)
      for (int k = 0; k < NUM_SLOTS; k++)
        if (linked[(start + k) % NUM_SLOTS] == want_linked)
          return SLOT_W'((start + k) % NUM_SLOTS);
    return SLOT_W'(start);
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return KEY_MAX;
      2: return KEY_MAX - 1'b1;
      3, 4, 5: return KEY_BITS'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input logic [CMD_W-1:0] c, input logic [LIST_W-1:0] l,
                           input logic [SLOT_W-1:0] s, input logic [KEY_BITS-1:0] v);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid   = 1'b1;
    command    = c;
    list_id    = l;
    slot       = s;
    item_value = v;
    // ready only moves at rising edges, so its level here holds at the next one
    while (!in_ready) @(negedge clk_i);
    @(posedge clk_i);
    case (c)
      CMD_RESET: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (linked[i] && holder[i] == l) linked[i] = 1'b0;
      end
      CMD_DETACH, CMD_REMOVE: linked[s] = 1'b0;
      CMD_INS_CUR, CMD_INS_SORT: begin
        if (!linked[s]) begin
          linked[s] = 1'b1;
          holder[s] = l;
        end
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // receiver: random hold bursts, plus one long hold on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && long_holds_done != long_holds_asked) begin
        long_holds_done++;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 13);
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin : timeout
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int roll;
    logic [LIST_W-1:0] l;
    for (int i = 0; i < NUM_SLOTS; i++) linked[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    push_item(CMD_ADVANCE,  2'd0, 4'd0,  '0);
    push_item(CMD_INS_SORT, 2'd0, 4'd0,  32'h10);
    push_item(CMD_INS_SORT, 2'd0, 4'd1,  '0);
    push_item(CMD_INS_SORT, 2'd0, 4'd2,  KEY_MAX);
    push_item(CMD_INS_SORT, 2'd0, 4'd3,  32'h10);
    push_item(CMD_INS_SORT, 2'd0, 4'd4,  KEY_MAX - 1'b1);
    push_item(CMD_INS_SORT, 2'd0, 4'd3,  32'h5);
    push_item(CMD_ADVANCE,  2'd0, 4'd0,  '0);
    push_item(CMD_ADVANCE,  2'd0, 4'd0,  '0);
    push_item(CMD_INS_CUR,  2'd0, 4'd5,  32'h7);
    push_item(CMD_REMOVE,   2'd2, 4'd0,  '0);
    push_item(CMD_REMOVE,   2'd0, 4'd0,  '0);
    push_item(CMD_INS_CUR,  2'd1, 4'd15, KEY_MAX);
    push_item(CMD_ADVANCE,  2'd1, 4'd0,  '0);
    push_item(CMD_ADVANCE,  2'd1, 4'd0,  '0);
    push_item(CMD_DETACH,   2'd3, 4'd15, '0);
    push_item(CMD_DETACH,   2'd2, 4'd15, '0);
    push_item(CMD_ADVANCE,  2'd1, 4'd0,  '0);
    push_item(CMD_INS_SORT, 2'd3, 4'd6,  '0);
    push_item(CMD_RESET,    2'd0, 4'd0,  '0);
    push_item(CMD_REMOVE,   2'd0, 4'd1,  '0);
    push_item(CMD_UNUSED_LO, 2'd3, 4'd9, '0);
    push_item(CMD_UNUSED_HI, 2'd2, 4'd15, KEY_MAX);
    push_item(CMD_RESET,    2'd3, 4'd0,  '0);
    push_item(CMD_INS_SORT, 2'd2, 4'd14, KEY_MAX);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 250) long_holds_asked++;
      if (i == 450) begin
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      if (i == RANDOM_ITEMS - 120) quiet = 1'b1;
      roll = $urandom_range(0, 99);
      l = $urandom_range(0, 1) ? 2'd0 : LIST_W'($urandom_range(0, NUM_LISTS - 1));
      if (roll < 30)      push_item(CMD_INS_SORT, l, pick_slot(1'b0), pick_key());
      else if (roll < 45) push_item(CMD_INS_CUR, l, pick_slot(1'b0), pick_key());
      else if (roll < 65) push_item(CMD_REMOVE, l, pick_slot(1'b1), $urandom);
      else if (roll < 73) push_item(CMD_DETACH, l, pick_slot(1'b1), $urandom);
      else if (roll < 93) push_item(CMD_ADVANCE, l, SLOT_W'($urandom), $urandom);
      else if (roll < 97) push_item(CMD_RESET, l, SLOT_W'($urandom), $urandom);
      else push_item($urandom_range(0, 1) ? CMD_UNUSED_LO : CMD_UNUSED_HI, l,
                     SLOT_W'($urandom), $urandom);
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("tb: %0d results checked, %0d with error set, %0d advances onto an item",
             results_seen, error_results, cursor_hits);
    $display("tb: %0d long receiver hold(s), one full drain by the sender", long_holds_done);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
